// ===== sv/dpb_pkg.sv =====
// ============================================================================
// dpb_pkg
// Shared types and constants for the depth pixel back-projection block.
// ============================================================================
package dpb_pkg;

    // configuration port
    localparam int CFG_DATA_BITS = 25;
    localparam int CFG_IDX_BITS  = 3;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_X_HALF = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_Y_HALF = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_INV_FOCAL_X   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_INV_FOCAL_Y   = 3'd5;

    // register widths and reset values (fx = fy = 525, cx = 319.5, cy = 239.5)
    localparam int GEOM_BITS = 13;
    localparam int INV_BITS  = 25;
    localparam logic [GEOM_BITS-1:0] RESET_IMAGE_WIDTH   = 13'd640;
    localparam logic [GEOM_BITS-1:0] RESET_IMAGE_HEIGHT  = 13'd480;
    localparam logic [GEOM_BITS-1:0] RESET_CENTER_X_HALF = 13'd639;
    localparam logic [GEOM_BITS-1:0] RESET_CENTER_Y_HALF = 13'd479;
    localparam logic [INV_BITS-1:0]  RESET_INV_FOCAL     = 25'd31957;

    // product is in 2^-25 mm, result in Q8 mm
    localparam int FRAC_SHIFT = 17;
    localparam int ROUND_BIT  = 16;
    localparam logic [63:0] SAT_POS = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] SAT_NEG = 64'h0000_0000_8000_0000;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = 2;

    // image geometry registers seen by the front
    typedef struct packed {
        logic [GEOM_BITS-1:0] image_width;
        logic [GEOM_BITS-1:0] image_height;
        logic [GEOM_BITS-1:0] center_x_half;
        logic [GEOM_BITS-1:0] center_y_half;
    } geom_cfg_t;

    // per-pixel flags and color carried with the magnitudes
    typedef struct packed {
        logic       neg_x;
        logic       neg_y;
        logic       eof;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pix_tag_t;

endpackage

// ===== sv/depth_pixel_backprojection_top.sv =====
// ============================================================================
// depth_pixel_backprojection_top
// Pinhole back-projection of raster depth pixels into colored 3D points.
// ============================================================================
//
//   channel  direction  handshake            payload
//   in       sink       in_valid / in_stall  depth_raw, blue/green/red_in, frame_start
//   out      source     out_valid/out_stall  point_x/y/z, color, point_valid, end_of_frame
//   cfg      sink       cfg_we               cfg_index, cfg_data
//
// one pixel per clock sustained while out_stall is low; an accepted pixel passes
// the queue, the two multiply stages and the output register before out_valid.
// a 4-beat queue sits between the position front and the multiply pipeline;
// in_stall rises only when it is full, which takes a stalled output.
// reset clears counters, queue and pipeline valids and loads the default
// camera registers; there is no clearing pass.
// ============================================================================
module depth_pixel_backprojection_top
    import dpb_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int DEPTH_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [15:0]              depth_raw,
    input  logic [7:0]               blue_in,
    input  logic [7:0]               green_in,
    input  logic [7:0]               red_in,
    input  logic                     frame_start,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [31:0]       point_x,
    output logic signed [31:0]       point_y,
    output logic [15:0]              point_z,
    output logic [7:0]               red_out,
    output logic [7:0]               green_out,
    output logic [7:0]               blue_out,
    output logic                     point_valid,
    output logic                     end_of_frame
);

    localparam int DW     = (COORD_BITS + 2 > GEOM_BITS + 1) ? COORD_BITS + 2 : GEOM_BITS + 1;
    localparam int MW     = DW - 1;
    localparam int TAGW   = $bits(pix_tag_t);
    localparam int ENTRYW = 2 * MW + DEPTH_BITS + TAGW;

    geom_cfg_t             geom_reg;
    logic [INV_BITS-1:0]   inv_x_reg, inv_y_reg;
    logic                  push, pop, q_full, q_empty;
    logic [MW-1:0]         f_mag_x, f_mag_y, b_mag_x, b_mag_y;
    logic [DEPTH_BITS-1:0] f_z, b_z;
    pix_tag_t              f_tag, b_tag;
    logic [ENTRYW-1:0]     q_in, q_out;
    logic [31:0]           x_raw, y_raw;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            geom_reg.image_width   <= RESET_IMAGE_WIDTH;
            geom_reg.image_height  <= RESET_IMAGE_HEIGHT;
            geom_reg.center_x_half <= RESET_CENTER_X_HALF;
            geom_reg.center_y_half <= RESET_CENTER_Y_HALF;
            inv_x_reg              <= RESET_INV_FOCAL;
            inv_y_reg              <= RESET_INV_FOCAL;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:   geom_reg.image_width   <= cfg_data[GEOM_BITS-1:0];
                REG_IMAGE_HEIGHT:  geom_reg.image_height  <= cfg_data[GEOM_BITS-1:0];
                REG_CENTER_X_HALF: geom_reg.center_x_half <= cfg_data[GEOM_BITS-1:0];
                REG_CENTER_Y_HALF: geom_reg.center_y_half <= cfg_data[GEOM_BITS-1:0];
                REG_INV_FOCAL_X:   inv_x_reg              <= cfg_data[INV_BITS-1:0];
                REG_INV_FOCAL_Y:   inv_y_reg              <= cfg_data[INV_BITS-1:0];
                default: ;
            endcase
        end
    end

    // input beat goes straight into the queue
    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    dpb_front #(
        .COORD_BITS (COORD_BITS),
        .DEPTH_BITS (DEPTH_BITS),
        .MAG_BITS   (MW)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (push),
        .geom        (geom_reg),
        .depth_raw   (depth_raw),
        .blue_in     (blue_in),
        .green_in    (green_in),
        .red_in      (red_in),
        .frame_start (frame_start),
        .mag_x       (f_mag_x),
        .mag_y       (f_mag_y),
        .depth_z     (f_z),
        .tag         (f_tag)
    );

    assign q_in = {f_mag_x, f_mag_y, f_z, f_tag};

    dpb_queue #(
        .WIDTH (ENTRYW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (q_in),
        .pop       (pop),
        .pop_data  (q_out),
        .full      (q_full),
        .empty     (q_empty)
    );

    assign {b_mag_x, b_mag_y, b_z, b_tag} = q_out;

    dpb_back #(
        .DEPTH_BITS (DEPTH_BITS),
        .MAG_BITS   (MW)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_pop        (pop),
        .mag_x        (b_mag_x),
        .mag_y        (b_mag_y),
        .depth_z      (b_z),
        .tag          (b_tag),
        .inv_focal_x  (inv_x_reg),
        .inv_focal_y  (inv_y_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .point_x      (x_raw),
        .point_y      (y_raw),
        .point_z      (point_z),
        .red_out      (red_out),
        .green_out    (green_out),
        .blue_out     (blue_out),
        .point_valid  (point_valid),
        .end_of_frame (end_of_frame)
    );

    assign point_x = $signed(x_raw);
    assign point_y = $signed(y_raw);

endmodule

// ===== sv/dpb_front.sv =====
// ============================================================================
// dpb_front
// Pixel position tracking and offset classification from the principal point.
// ============================================================================
module dpb_front
    import dpb_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int DEPTH_BITS = 16,
    parameter int MAG_BITS   = 13
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  geom_cfg_t             geom,
    input  logic [15:0]           depth_raw,
    input  logic [7:0]            blue_in,
    input  logic [7:0]            green_in,
    input  logic [7:0]            red_in,
    input  logic                  frame_start,
    output logic [MAG_BITS-1:0]   mag_x,
    output logic [MAG_BITS-1:0]   mag_y,
    output logic [DEPTH_BITS-1:0] depth_z,
    output pix_tag_t              tag
);

    localparam int SW = COORD_BITS + 1;
    localparam int CW = (SW > GEOM_BITS) ? SW : GEOM_BITS;
    localparam int DW = MAG_BITS + 1;

    logic [COORD_BITS-1:0] col_reg, col_next, row_reg, row_next;
    logic [COORD_BITS-1:0] col, row;
    logic [SW-1:0]         w, h;
    logic                  last_col, last_row;
    logic signed [DW-1:0]  dx, dy;

    // size register to 1 .. 2^COORD_BITS
    function automatic logic [SW-1:0] clamp_size(input logic [GEOM_BITS-1:0] v);
        logic [CW-1:0] ve;
        logic [CW-1:0] te;
        ve = CW'(v);
        te = CW'(1) << COORD_BITS;
        if (v == '0)
            return SW'(1);
        else if (ve > te)
            return SW'(te);
        else
            return SW'(ve);
    endfunction

    // position of this pixel
    always_comb
    begin
        w   = clamp_size(geom.image_width);
        h   = clamp_size(geom.image_height);
        col = frame_start ? '0 : col_reg;
        row = frame_start ? '0 : row_reg;
        last_col = ({1'b0, col} + SW'(1)) >= w;
        last_row = ({1'b0, row} + SW'(1)) >= h;
    end

    // counter advance
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row + COORD_BITS'(1);
            end
            else
            begin
                col_next = col + COORD_BITS'(1);
                row_next = row;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // signed offsets in half pixels, split into sign and magnitude
    always_comb
    begin
        dx = $signed(DW'({col, 1'b0})) - $signed(DW'(geom.center_x_half));
        dy = $signed(DW'({row, 1'b0})) - $signed(DW'(geom.center_y_half));
        mag_x = dx[DW-1] ? MAG_BITS'(-dx) : MAG_BITS'(dx);
        mag_y = dy[DW-1] ? MAG_BITS'(-dy) : MAG_BITS'(dy);
        depth_z = depth_raw[DEPTH_BITS-1:0];
        tag.neg_x = dx[DW-1];
        tag.neg_y = dy[DW-1];
        tag.eof   = ({1'b0, col} == (w - SW'(1))) && ({1'b0, row} == (h - SW'(1)));
        tag.red   = red_in;
        tag.green = green_in;
        tag.blue  = blue_in;
    end

endmodule

// ===== sv/dpb_queue.sv =====
// ============================================================================
// dpb_queue
// Short register queue that decouples the front from the multiply pipeline.
// ============================================================================
module dpb_queue
    import dpb_pkg::*;
#(
    parameter int WIDTH = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);

    logic [WIDTH-1:0]     slot_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_BITS:0]   count_reg, count_next;

    assign full     = (count_reg == (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + (QPTR_BITS+1)'(1);
        else if (pop && !push)
            count_next = count_reg - (QPTR_BITS+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_BITS'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_BITS'(1);
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== sv/dpb_back.sv =====
// ============================================================================
// dpb_back
// Two-multiply pipeline with rounding, saturation and the output register.
// ============================================================================
module dpb_back
    import dpb_pkg::*;
#(
    parameter int DEPTH_BITS = 16,
    parameter int MAG_BITS   = 13
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_empty,
    output logic                  q_pop,
    input  logic [MAG_BITS-1:0]   mag_x,
    input  logic [MAG_BITS-1:0]   mag_y,
    input  logic [DEPTH_BITS-1:0] depth_z,
    input  pix_tag_t              tag,
    input  logic [INV_BITS-1:0]   inv_focal_x,
    input  logic [INV_BITS-1:0]   inv_focal_y,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [31:0]           point_x,
    output logic [31:0]           point_y,
    output logic [15:0]           point_z,
    output logic [7:0]            red_out,
    output logic [7:0]            green_out,
    output logic [7:0]            blue_out,
    output logic                  point_valid,
    output logic                  end_of_frame
);

    localparam int MZW = MAG_BITS + DEPTH_BITS;
    localparam int PW  = MZW + INV_BITS;

    logic                  adv;
    logic                  v1_reg, v2_reg, out_valid_reg;
    logic [MZW-1:0]        mz_x_reg, mz_y_reg;
    logic [PW-1:0]         p_x_reg, p_y_reg;
    logic [DEPTH_BITS-1:0] z1_reg, z2_reg;
    pix_tag_t              tag1_reg, tag2_reg;
    logic [31:0]           x_next, y_next;
    logic [31:0]           point_x_reg, point_y_reg;
    logic [15:0]           point_z_reg;
    logic [7:0]            red_reg, green_reg, blue_reg;
    logic                  point_valid_reg, eof_reg;

    // round magnitude to nearest, restore sign, clamp to 32 bits
    function automatic logic [31:0] round_sat(input logic [PW-1:0] p, input logic neg);
        logic [PW:0] s;
        logic [63:0] q;
        s = {1'b0, p} + ((PW+1)'(1) << ROUND_BIT);
        q = 64'(s >> FRAC_SHIFT);
        if (neg)
        begin
            if (q >= SAT_NEG)
                return SAT_NEG[31:0];
            else
                return 32'(64'd0 - q);
        end
        else
        begin
            if (q > SAT_POS)
                return SAT_POS[31:0];
            else
                return q[31:0];
        end
    endfunction

    // whole pipeline moves when the output register can take a beat
    assign adv   = !out_valid_reg || !out_stall;
    assign q_pop = adv && !q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= !q_empty;
            v2_reg        <= v1_reg;
            out_valid_reg <= v2_reg;
        end
    end

    // stage 1: offset times depth
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mz_x_reg <= MZW'(mag_x) * MZW'(depth_z);
            mz_y_reg <= MZW'(mag_y) * MZW'(depth_z);
            z1_reg   <= depth_z;
            tag1_reg <= tag;
        end
    end

    // stage 2: times reciprocal focal length
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_x_reg  <= PW'(mz_x_reg) * PW'(inv_focal_x);
            p_y_reg  <= PW'(mz_y_reg) * PW'(inv_focal_y);
            z2_reg   <= z1_reg;
            tag2_reg <= tag1_reg;
        end
    end

    always_comb
    begin
        x_next = round_sat(p_x_reg, tag2_reg.neg_x);
        y_next = round_sat(p_y_reg, tag2_reg.neg_y);
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            point_x_reg     <= x_next;
            point_y_reg     <= y_next;
            point_z_reg     <= 16'(z2_reg);
            red_reg         <= tag2_reg.red;
            green_reg       <= tag2_reg.green;
            blue_reg        <= tag2_reg.blue;
            point_valid_reg <= (z2_reg != '0);
            eof_reg         <= tag2_reg.eof;
        end
    end

    assign out_valid    = out_valid_reg;
    assign point_x      = point_x_reg;
    assign point_y      = point_y_reg;
    assign point_z      = point_z_reg;
    assign red_out      = red_reg;
    assign green_out    = green_reg;
    assign blue_out     = blue_reg;
    assign point_valid  = point_valid_reg;
    assign end_of_frame = eof_reg;

endmodule

// ===== sv/dpb_checker.sv =====
// ============================================================================
// dpb_checker
// Port-level checks on the output channel, bound to the top level.
// ============================================================================
module dpb_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [31:0] point_x,
    input logic signed [31:0] point_y,
    input logic [15:0]        point_z,
    input logic [7:0]         red_out,
    input logic [7:0]         green_out,
    input logic [7:0]         blue_out,
    input logic               point_valid,
    input logic               end_of_frame
);

    // a stalled beat stays offered
    a_valid_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("out_valid dropped while stalled");

    // a stalled beat keeps its payload
    a_payload_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(point_x) && $stable(point_y)
            && $stable(point_z) && $stable(red_out) && $stable(green_out)
            && $stable(blue_out) && $stable(point_valid) && $stable(end_of_frame))
        else $error("output payload changed while stalled");

    // no measurement gives a point at the origin
    a_invalid_origin: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !point_valid |-> point_z == 16'd0 && point_x == 32'sd0
            && point_y == 32'sd0)
        else $error("invalid point not at origin");

    // a kept point has depth
    a_valid_depth: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && point_valid |-> point_z != 16'd0)
        else $error("valid point with zero depth");

endmodule

bind depth_pixel_backprojection_top dpb_checker u_dpb_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .point_x      (point_x),
    .point_y      (point_y),
    .point_z      (point_z),
    .red_out      (red_out),
    .green_out    (green_out),
    .blue_out     (blue_out),
    .point_valid  (point_valid),
    .end_of_frame (end_of_frame)
);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Checks each point of the depth back-projection block against a predictor.
// Pixels go in through valid/stall bursts while the output side stalls on its
// own random pattern. The predictor follows the column and row counters,
// projects x and y in Q8 mm with rounding and saturation, and keeps the
// expected points in order. Every output beat is compared field by field.
// Camera registers are changed only between phases, after all points are out.
// ============================================================================
import dpb_pkg::*;

typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [15:0]        z;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic               valid;
    logic               eof;
} cloud_point_t;

typedef struct packed {
    logic [GEOM_BITS-1:0] width;
    logic [GEOM_BITS-1:0] height;
    logic [GEOM_BITS-1:0] center_x_half;
    logic [GEOM_BITS-1:0] center_y_half;
    logic [INV_BITS-1:0]  inv_fx;
    logic [INV_BITS-1:0]  inv_fy;
} camera_cfg_t;

// expected points in arrival order, with its own copy of counters and camera
class point_scoreboard;
    localparam int POS_BITS = 12;
    localparam int unsigned POS_MASK = (1 << POS_BITS) - 1;

    logic [GEOM_BITS-1:0] image_width;
    logic [GEOM_BITS-1:0] image_height;
    logic [GEOM_BITS-1:0] center_x_half;
    logic [GEOM_BITS-1:0] center_y_half;
    logic [INV_BITS-1:0]  inv_focal_x;
    logic [INV_BITS-1:0]  inv_focal_y;
    int unsigned          column_pos;
    int unsigned          row_pos;
    cloud_point_t         pending_points[$];
    int                   error_count;

    function new();
        image_width   = RESET_IMAGE_WIDTH;
        image_height  = RESET_IMAGE_HEIGHT;
        center_x_half = RESET_CENTER_X_HALF;
        center_y_half = RESET_CENTER_Y_HALF;
        inv_focal_x   = RESET_INV_FOCAL;
        inv_focal_y   = RESET_INV_FOCAL;
        column_pos    = 0;
        row_pos       = 0;
        error_count   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_BITS-1:0] index, logic [CFG_DATA_BITS-1:0] data);
        case (index)
            REG_IMAGE_WIDTH:   image_width   = data[GEOM_BITS-1:0];
            REG_IMAGE_HEIGHT:  image_height  = data[GEOM_BITS-1:0];
            REG_CENTER_X_HALF: center_x_half = data[GEOM_BITS-1:0];
            REG_CENTER_Y_HALF: center_y_half = data[GEOM_BITS-1:0];
            REG_INV_FOCAL_X:   inv_focal_x   = data[INV_BITS-1:0];
            REG_INV_FOCAL_Y:   inv_focal_y   = data[INV_BITS-1:0];
            default: ;
        endcase
    endfunction

    // zero acts as one, anything past the counter range acts as the full range
    function int unsigned clamp_extent(logic [GEOM_BITS-1:0] v);
        if (v == 0)
            return 1;
        if (v > (1 << POS_BITS))
            return 1 << POS_BITS;
        return 32'(v);
    endfunction

    // (2*pos - center) * z * inv is in 2^-25 mm; round magnitude, then saturate
    function logic [31:0] project_axis(int unsigned pos, logic [GEOM_BITS-1:0] center_half,
                                       logic [15:0] z, logic [INV_BITS-1:0] inv);
        longint          diff;
        longint unsigned mag;
        longint unsigned prod;
        longint unsigned q;
        diff = 2 * longint'(pos) - longint'(center_half);
        if (diff < 0)
            mag = -diff;
        else
            mag = diff;
        prod = mag * 64'(z) * 64'(inv);
        q = (prod + (64'd1 << ROUND_BIT)) >> FRAC_SHIFT;
        if (diff < 0)
        begin
            if (q >= SAT_NEG)
                return 32'(SAT_NEG);
            return 32'(64'h1_0000_0000 - q);
        end
        if (q > SAT_POS)
            return 32'(SAT_POS);
        return 32'(q);
    endfunction

    function void note_pixel(logic [15:0] depth, logic [7:0] blue, logic [7:0] green,
                             logic [7:0] red, logic frame_start);
        cloud_point_t p;
        int unsigned  w;
        int unsigned  h;
        w = clamp_extent(image_width);
        h = clamp_extent(image_height);
        if (frame_start)
        begin
            column_pos = 0;
            row_pos    = 0;
        end
        p.x     = project_axis(column_pos, center_x_half, depth, inv_focal_x);
        p.y     = project_axis(row_pos, center_y_half, depth, inv_focal_y);
        p.z     = depth;
        p.red   = red;
        p.green = green;
        p.blue  = blue;
        p.valid = (depth != 0);
        p.eof   = (column_pos == w - 1) && (row_pos == h - 1);
        pending_points = {pending_points, p};
        // a counter past its bound (size lowered mid-frame) wraps on this pixel
        if (column_pos + 1 >= w)
        begin
            column_pos = 0;
            row_pos    = (row_pos + 1 >= h) ? 0 : ((row_pos + 1) & POS_MASK);
        end
        else
        begin
            column_pos = (column_pos + 1) & POS_MASK;
        end
    endfunction

    function void compare_field(string field, longint want, longint got);
        if (want != got)
        begin
            error_count++;
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        end
    endfunction

    function void check_point(cloud_point_t got);
        cloud_point_t want;
        if (pending_points.size() == 0)
        begin
            error_count++;
            $display("%0t: point expected none, got x=%0d y=%0d z=%0d", $time,
                     got.x, got.y, got.z);
            return;
        end
        want = pending_points.pop_front();
        compare_field("point_x", 64'(want.x), 64'(got.x));
        compare_field("point_y", 64'(want.y), 64'(got.y));
        compare_field("point_z", 64'(want.z), 64'(got.z));
        compare_field("red_out", 64'(want.red), 64'(got.red));
        compare_field("green_out", 64'(want.green), 64'(got.green));
        compare_field("blue_out", 64'(want.blue), 64'(got.blue));
        compare_field("point_valid", 64'(want.valid), 64'(got.valid));
        compare_field("end_of_frame", 64'(want.eof), 64'(got.eof));
    endfunction

    function int outstanding();
        return pending_points.size();
    endfunction
endclass

module tb_top;

    localparam int HALF_PERIOD = 6;
    localparam int unsigned TIMEOUT_NS = 5_000_000;
    localparam int RANDOM_PHASES = 10;
    // indexes past the last register, the block ignores them
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_B = 3'd7;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [15:0]              depth_raw = '0;
    logic [7:0]               blue_in = '0;
    logic [7:0]               green_in = '0;
    logic [7:0]               red_in = '0;
    logic                     frame_start = 1'b0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [31:0]       point_x;
    logic signed [31:0]       point_y;
    logic [15:0]              point_z;
    logic [7:0]               red_out;
    logic [7:0]               green_out;
    logic [7:0]               blue_out;
    logic                     point_valid;
    logic                     end_of_frame;

    point_scoreboard sb;
    cloud_point_t    seen_point;
    int              burst_left = 0;

    depth_pixel_backprojection_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .depth_raw    (depth_raw),
        .blue_in      (blue_in),
        .green_in     (green_in),
        .red_in       (red_in),
        .frame_start  (frame_start),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .point_x      (point_x),
        .point_y      (point_y),
        .point_z      (point_z),
        .red_out      (red_out),
        .green_out    (green_out),
        .blue_out     (blue_out),
        .point_valid  (point_valid),
        .end_of_frame (end_of_frame)
    );

    // clock
    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // beat monitor: input beats feed the predictor, output beats get checked
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_pixel(depth_raw, blue_in, green_in, red_in, frame_start);
            if (out_valid && !out_stall)
            begin
                seen_point.x     = point_x;
                seen_point.y     = point_y;
                seen_point.z     = point_z;
                seen_point.red   = red_out;
                seen_point.green = green_out;
                seen_point.blue  = blue_out;
                seen_point.valid = point_valid;
                seen_point.eof   = end_of_frame;
                sb.check_point(seen_point);
            end
        end
    end

    // output stall pattern: short stalls, short open runs, some long open runs
    initial
    begin : stall_pattern
        int run;
        bit level;
        forever
        begin
            case ($urandom_range(0, 7))
                0:       begin level = 1'b0; run = $urandom_range(40, 100); end
                1, 2, 3: begin level = 1'b1; run = $urandom_range(1, 12); end
                default: begin level = 1'b0; run = $urandom_range(1, 10); end
            endcase
            repeat (run)
            begin
                @(negedge clk);
                out_stall <= level;
            end
        end
    end

    // idle input with junk on the payload
    task automatic idle_cycles(int n);
        repeat (n)
        begin
            @(negedge clk);
            in_valid    <= 1'b0;
            depth_raw   <= 16'($urandom);
            blue_in     <= 8'($urandom);
            green_in    <= 8'($urandom);
            red_in      <= 8'($urandom);
            frame_start <= 1'($urandom);
        end
    endtask

    // one pixel beat, sent in bursts with random gaps between them
    task automatic push_pixel(logic [15:0] depth, logic [7:0] blue, logic [7:0] green,
                              logic [7:0] red, logic fs);
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) != 0)
                idle_cycles($urandom_range(1, 6));
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        @(negedge clk);
        in_valid    <= 1'b1;
        depth_raw   <= depth;
        blue_in     <= blue;
        green_in    <= green;
        red_in      <= red;
        frame_start <= fs;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic push_random_pixel(bit allow_fs);
        logic [15:0] depth;
        case ($urandom_range(0, 7))
            0:       depth = '0;
            1:       depth = 16'hFFFF;
            2:       depth = 16'($urandom_range(1, 255));
            default: depth = 16'($urandom);
        endcase
        push_pixel(depth, 8'($urandom), 8'($urandom), 8'($urandom),
                   allow_fs && ($urandom_range(0, 31) == 0));
    endtask

    // hold input until every expected point is out, then let the pipe settle
    task automatic wait_drain();
        idle_cycles(1);
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        burst_left = 0;
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] index, logic [CFG_DATA_BITS-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        sb.write_reg(index, data);
    endtask

    task automatic program_camera(camera_cfg_t cam, bit with_spare);
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_BITS'(cam.width));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_BITS'(cam.height));
        write_reg(REG_CENTER_X_HALF, CFG_DATA_BITS'(cam.center_x_half));
        write_reg(REG_CENTER_Y_HALF, CFG_DATA_BITS'(cam.center_y_half));
        write_reg(REG_INV_FOCAL_X, cam.inv_fx);
        write_reg(REG_INV_FOCAL_Y, cam.inv_fy);
        if (with_spare)
        begin
            write_reg(REG_SPARE_A, CFG_DATA_BITS'($urandom));
            write_reg(REG_SPARE_B, CFG_DATA_BITS'($urandom));
        end
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // mostly tiny frames so frames wrap often, with the range ends mixed in
    function automatic logic [GEOM_BITS-1:0] random_extent();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 13'd8191;
            2:       return 13'd4096;
            3:       return GEOM_BITS'($urandom);
            default: return GEOM_BITS'($urandom_range(1, 12));
        endcase
    endfunction

    function automatic logic [GEOM_BITS-1:0] random_center(logic [GEOM_BITS-1:0] extent);
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return 13'd8191;
            2:       return GEOM_BITS'($urandom);
            default: return GEOM_BITS'($urandom_range(0, 2 * extent));
        endcase
    endfunction

    function automatic logic [INV_BITS-1:0] random_inv();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 25'h1FF_FFFF;
            2:       return 25'd16777216;
            3:       return INV_BITS'($urandom);
            default: return INV_BITS'($urandom_range(20000, 60000));
        endcase
    endfunction

    // main sequence
    initial
    begin
        camera_cfg_t cam;
        int          n_items;
        sb = new();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset camera: depth and color extremes, frame start mid-row
        push_pixel(16'd1000, 8'h00, 8'hFF, 8'h00, 1'b1);
        push_pixel(16'd0, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        push_pixel(16'hFFFF, 8'h12, 8'h34, 8'h56, 1'b0);
        push_pixel(16'd1, 8'hAA, 8'h55, 8'h0F, 1'b0);
        push_pixel(16'h8000, 8'h01, 8'h80, 8'hFE, 1'b0);
        push_pixel(16'd500, 8'h00, 8'h00, 8'h00, 1'b1);
        wait_drain();

        // one whole 4x3 frame and its wrap into the next
        cam = '{width: 13'd4, height: 13'd3, center_x_half: 13'd3, center_y_half: 13'd2,
                inv_fx: 25'd16777216, inv_fy: 25'd16777216};
        program_camera(cam, 1'b0);
        for (int k = 0; k < 14; k++)
            push_pixel((k == 5) ? 16'd0 : 16'(k * 700 + 1), 8'(k), 8'(k * 17),
                       8'(255 - k), k == 0);
        wait_drain();

        // random phases, the first three pinned to the corners
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                // one pixel per row, tall frame: both saturation signs
                0: cam = '{width: 13'd1, height: 13'd8191, center_x_half: 13'd8191,
                           center_y_half: 13'd0, inv_fx: 25'h1FF_FFFF, inv_fy: 25'h1FF_FFFF};
                // zero sizes act as one, zero focal gives zero coordinates
                1: cam = '{width: 13'd0, height: 13'd0, center_x_half: random_center(13'd1),
                           center_y_half: random_center(13'd1), inv_fx: '0, inv_fy: '0};
                // wide rows, short frame
                2: cam = '{width: 13'd8191, height: 13'd3, center_x_half: 13'd0,
                           center_y_half: 13'd8191, inv_fx: 25'd16777216, inv_fy: 25'd1};
                default:
                begin
                    cam.width         = random_extent();
                    cam.height        = random_extent();
                    cam.center_x_half = random_center(cam.width);
                    cam.center_y_half = random_center(cam.height);
                    cam.inv_fx        = random_inv();
                    cam.inv_fy        = random_inv();
                end
            endcase
            program_camera(cam, p == 3);
            // the tall phase needs long runs of rows to reach saturation
            n_items = (p == 0) ? 90 : 50;
            for (int i = 0; i < n_items; i++)
                push_random_pixel(p != 0);
            wait_drain();
        end

        repeat (8) @(posedge clk);
        if (sb.error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // watchdog
    initial
    begin
        #(TIMEOUT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
